// File: rtl/gstd_pkg.sv
// gstd_pkg: shared types and constants of the gcd segment tree block
// no dependencies
`timescale 1ns / 1ps

package gstd_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int LEN_W = 11;
  localparam int SHF_W = $clog2(VAL_W);

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_RDL,
    ST_U_RDR,
    ST_U_GO,
    ST_U_WAIT,
    ST_Q_NORM,
    ST_Q_RD,
    ST_Q_GO,
    ST_Q_WAIT
  } state_t;

endpackage

// File: rtl/gstd_if.sv
// gstd_in_if / gstd_out_if: valid-ready channels of the gcd segment tree block
// depends on gstd_pkg
`timescale 1ns / 1ps

interface gstd_in_if import gstd_pkg::*; ();
  logic valid;
  logic ready;
  logic cmd;
  idx_t index;
  val_t value;
  val_t threshold;

  modport source (output valid, cmd, index, value, threshold, input ready);
  modport sink (input valid, cmd, index, value, threshold, output ready);
endinterface

interface gstd_out_if import gstd_pkg::*; ();
  logic valid;
  logic ready;
  logic found;
  len_t run_length;

  modport source (output valid, found, run_length, input ready);
  modport sink (input valid, found, run_length, output ready);
endinterface

// File: rtl/gstd_gcd_unit.sv
// gstd_gcd_unit: binary gcd, one shift or subtract per cycle
// depends on gstd_pkg
`timescale 1ns / 1ps

module gstd_gcd_unit import gstd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  val_t a_in,
  input  val_t b_in,
  output logic done,
  output val_t res
);

  val_t             a_r, a_nxt;
  val_t             b_r, b_nxt;
  logic [SHF_W-1:0] k_r, k_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  val_t             res_r, res_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    if (start) begin
      a_nxt    = a_in;
      b_nxt    = b_in;
      k_nxt    = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      priority if (a_r == '0 || b_r == '0) begin
        res_nxt  = (a_r | b_r) << k_r;
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = (a_r - b_r) >> 1;
      end else begin
        b_nxt = (b_r - a_r) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// File: rtl/gcd_segment_tree_descent.sv
// gcd_segment_tree_descent: gcd segment tree with shortest-run descent
// update: log2(SIZE) levels, each reads the left and right child and then runs a binary gcd of the two
// query: at most 2*log2(SIZE)+1 node visits, each a memory read and one gcd, with climbs between them
// one item at a time; the next transfer waits until the item is done and any result of it is taken
// after reset all 2*SIZE words of the tree memory are cleared before the first transfer
// SIZE must be a power of two; depends on gstd_pkg, gstd_if, gstd_gcd_unit
`timescale 1ns / 1ps

module gcd_segment_tree_descent import gstd_pkg::*; #(
  parameter int SIZE = 1024
) (
  input logic         clk,
  input logic         rst_n,
  gstd_in_if.sink     in_ch,
  gstd_out_if.source  out_ch
);

  localparam int LW = $clog2(SIZE);
  localparam int AW = LW + 1;
  localparam int DEPTH = 2 * SIZE;

  typedef logic [AW-1:0] addr_t;
  typedef logic [AW:0]   node_t;

  val_t mem [DEPTH];
  val_t rdata_r;
  addr_t raddr, waddr;
  logic we;
  val_t wdata;

  state_t state_r, state_nxt;
  addr_t  clr_r, clr_nxt;
  node_t  node_r, node_nxt;
  val_t   g_r, g_nxt;
  val_t   opa_r, opa_nxt;
  val_t   thr_r, thr_nxt;
  idx_t   start_r, start_nxt;
  logic   desc_r, desc_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   found_r, found_nxt;
  len_t   len_r, len_nxt;

  logic gcd_go, gcd_done;
  val_t gcd_a, gcd_b, gcd_res;
  logic in_xfer, hit;
  node_t node_inc;

  gstd_gcd_unit u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gcd_go),
    .a_in  (gcd_a),
    .b_in  (gcd_b),
    .done  (gcd_done),
    .res   (gcd_res)
  );

  assign in_ch.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign hit         = (gcd_res != '0) && (gcd_res <= thr_r);
  assign node_inc    = node_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    node_nxt      = node_r;
    g_nxt         = g_r;
    opa_nxt       = opa_r;
    thr_nxt       = thr_r;
    start_nxt     = start_r;
    desc_nxt      = desc_r;
    out_valid_nxt = out_valid_r;
    found_nxt     = found_r;
    len_nxt       = len_r;
    raddr         = node_r[AW-1:0];
    we            = 1'b0;
    waddr         = node_r[AW-1:0];
    wdata         = gcd_res;
    gcd_go        = 1'b0;
    gcd_a         = g_r;
    gcd_b         = rdata_r;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == addr_t'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_xfer) begin
          start_nxt = in_ch.index;
          thr_nxt   = in_ch.threshold;
          node_nxt  = node_t'(SIZE) + node_t'(in_ch.index);
          if (32'(in_ch.index) >= SIZE) begin
            if (in_ch.cmd == CMD_QUERY) begin
              out_valid_nxt = 1'b1;
              found_nxt     = 1'b0;
              len_nxt       = '0;
            end
          end else if (in_ch.cmd == CMD_UPDATE) begin
            we        = 1'b1;
            waddr     = addr_t'(SIZE) + addr_t'(in_ch.index);
            wdata     = in_ch.value;
            node_nxt  = (node_t'(SIZE) + node_t'(in_ch.index)) >> 1;
            state_nxt = ST_U_RDL;
          end else begin
            g_nxt     = '0;
            desc_nxt  = 1'b0;
            state_nxt = ST_Q_NORM;
          end
        end
      end
      ST_U_RDL: begin
        raddr     = {node_r[AW-2:0], 1'b0};
        state_nxt = ST_U_RDR;
      end
      ST_U_RDR: begin
        raddr     = {node_r[AW-2:0], 1'b1};
        opa_nxt   = rdata_r;
        state_nxt = ST_U_GO;
      end
      ST_U_GO: begin
        gcd_go    = 1'b1;
        gcd_a     = opa_r;
        state_nxt = ST_U_WAIT;
      end
      ST_U_WAIT: begin
        if (gcd_done) begin
          we       = 1'b1;
          node_nxt = node_r >> 1;
          if (node_r == node_t'(1)) state_nxt = ST_IDLE;
          else                      state_nxt = ST_U_RDL;
        end
      end
      ST_Q_NORM: begin
        // climb while this node is a left child
        if (!node_r[0]) node_nxt = node_r >> 1;
        else            state_nxt = ST_Q_RD;
      end
      ST_Q_RD: begin
        state_nxt = ST_Q_GO;
      end
      ST_Q_GO: begin
        gcd_go    = 1'b1;
        state_nxt = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        if (gcd_done) begin
          if (!desc_r) begin
            if (hit) begin
              if (node_r < node_t'(SIZE)) begin
                desc_nxt  = 1'b1;
                node_nxt  = node_r << 1;
                state_nxt = ST_Q_RD;
              end else begin
                out_valid_nxt = 1'b1;
                found_nxt     = 1'b1;
                len_nxt       = len_t'(32'(node_r[LW-1:0]) - 32'(start_r) + 32'd1);
                state_nxt     = ST_IDLE;
              end
            end else begin
              g_nxt    = gcd_res;
              node_nxt = node_inc;
              // reached the right edge of the tree
              if ((node_inc & node_r) == '0) begin
                out_valid_nxt = 1'b1;
                found_nxt     = 1'b0;
                len_nxt       = '0;
                state_nxt     = ST_IDLE;
              end else begin
                state_nxt = ST_Q_NORM;
              end
            end
          end else begin
            if (!hit) begin
              g_nxt    = gcd_res;
              node_nxt = node_inc;
            end
            if (hit && node_r >= node_t'(SIZE)) begin
              out_valid_nxt = 1'b1;
              found_nxt     = 1'b1;
              len_nxt       = len_t'(32'(node_r[LW-1:0]) - 32'(start_r) + 32'd1);
              state_nxt     = ST_IDLE;
            end else if (!hit && node_r >= node_t'(SIZE)) begin
              // sibling leaf must hold the end of the run
              out_valid_nxt = 1'b1;
              found_nxt     = 1'b1;
              len_nxt       = len_t'(32'(node_inc[LW-1:0]) - 32'(start_r) + 32'd1);
              state_nxt     = ST_IDLE;
            end else if (hit) begin
              node_nxt  = node_r << 1;
              state_nxt = ST_Q_RD;
            end else begin
              node_nxt  = node_inc << 1;
              state_nxt = ST_Q_RD;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      desc_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      desc_r      <= desc_nxt;
    end
    node_r  <= node_nxt;
    g_r     <= g_nxt;
    opa_r   <= opa_nxt;
    thr_r   <= thr_nxt;
    start_r <= start_nxt;
    found_r <= found_nxt;
    len_r   <= len_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = found_r;
  assign out_ch.run_length = len_r;

endmodule

// File: tb/sv/gcd_segment_tree_descent_tb.sv
// gcd_segment_tree_descent_tb: self-checking bench for the gcd segment tree block
// a directed table, then random updates and queries, most queries checked by a leaf-array model
// depends on gstd_pkg, gstd_if and the rtl of gcd_segment_tree_descent
`timescale 1ns / 1ps

module gcd_segment_tree_descent_tb import gstd_pkg::*; ();

  localparam int SIZE = 1024;
  localparam int N_RANDOM = 800;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic found;
    len_t run_length;
  } run_t;

  typedef struct {
    logic cmd;
    idx_t index;
    val_t value;
    val_t threshold;
    bit   typed;
    run_t want;
  } row_t;

  logic clk;
  logic rst_n;

  gstd_in_if  in_ch ();
  gstd_out_if out_ch ();

  gcd_segment_tree_descent #(.SIZE(SIZE)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  val_t leaf_val [SIZE];
  run_t pending_runs [$];
  int   mismatches;
  bit   hold_request;
  int   hold_cycles;

  function automatic val_t gcd_of(val_t a, val_t b);
    val_t t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // shortest run from start whose running gcd is nonzero and at most thr
  function automatic run_t shortest_run(idx_t start, val_t thr);
    run_t r;
    val_t g;
    r = '0;
    g = 0;
    for (int p = start; p < SIZE; p++) begin
      g = gcd_of(g, leaf_val[p]);
      if (g != 0 && g <= thr) begin
        r.found = 1'b1;
        r.run_length = len_t'(p - start + 1);
        return r;
      end
    end
    return r;
  endfunction

  function automatic val_t pick_value();
    val_t bases [8] = '{1, 2, 4, 6, 30, 210, 1024, 9699690};
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 0;
      default: return bases[$urandom_range(0, 7)] * $urandom_range(1, 50);
    endcase
  endfunction

  function automatic val_t pick_threshold();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
  end
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request && hold_cycles == 0) begin
      hold_cycles <= 3000;
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_cycles == 1) hold_cycles <= -1;
      case ($urandom_range(0, 9))
        0: out_ch.ready <= 1'b0;
        1: out_ch.ready <= ($urandom_range(0, 15) == 0);
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    run_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result found=%0d run_length=%0d",
                   out_ch.found, out_ch.run_length);
      end else begin
        want = pending_runs.pop_front();
        if (out_ch.found !== want.found || out_ch.run_length !== want.run_length) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("mismatch: expected found=%0d run_length=%0d, got found=%0d run_length=%0d",
                     want.found, want.run_length, out_ch.found, out_ch.run_length);
        end
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // one transfer on the input channel, then the model is advanced
  task automatic send(row_t row);
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= row.cmd;
    in_ch.index     <= row.index;
    in_ch.value     <= row.value;
    in_ch.threshold <= row.threshold;
    do @(posedge clk); while (!in_ch.ready);
    if (row.cmd == CMD_UPDATE) begin
      leaf_val[row.index] = row.value;
    end else if (row.typed) begin
      pending_runs.push_back(row.want);
    end else begin
      pending_runs.push_back(shortest_run(row.index, row.threshold));
    end
  endtask

  function automatic row_t mk(logic cmd, idx_t idx, val_t v, val_t thr,
                              bit typed = 0, logic f = 0, len_t len = 0);
    row_t r;
    r.cmd = cmd; r.index = idx; r.value = v; r.threshold = thr;
    r.typed = typed; r.want.found = f; r.want.run_length = len;
    return r;
  endfunction

  initial begin
    row_t table_rows [$];
    row_t row;
    int waited;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_UPDATE;
    in_ch.index = '0;
    in_ch.value = '0;
    in_ch.threshold = '0;
    hold_request = 1'b0;
    foreach (leaf_val[i]) leaf_val[i] = 0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // empty tree, last slot at full scale, zero threshold, emptied slots
    table_rows.push_back(mk(CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 1, 0, 0));
    table_rows.push_back(mk(CMD_QUERY, 1023, 5, 32'hFFFF_FFFF, 1, 0, 0));
    table_rows.push_back(mk(CMD_UPDATE, 1023, 32'hFFFF_FFFF, 0));
    table_rows.push_back(mk(CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 1, 1, 1024));
    table_rows.push_back(mk(CMD_QUERY, 1023, 0, 32'hFFFF_FFFE, 1, 0, 0));
    table_rows.push_back(mk(CMD_QUERY, 1023, 0, 32'hFFFF_FFFF, 1, 1, 1));
    table_rows.push_back(mk(CMD_UPDATE, 0, 12, 0));
    table_rows.push_back(mk(CMD_UPDATE, 1, 18, 0));
    table_rows.push_back(mk(CMD_QUERY, 0, 0, 6, 1, 1, 2));
    table_rows.push_back(mk(CMD_QUERY, 0, 0, 12, 1, 1, 1));
    table_rows.push_back(mk(CMD_QUERY, 0, 0, 0, 1, 0, 0));
    table_rows.push_back(mk(CMD_QUERY, 0, 0, 3));
    table_rows.push_back(mk(CMD_UPDATE, 1, 0, 0));
    table_rows.push_back(mk(CMD_QUERY, 1, 0, 5, 1, 0, 0));
    table_rows.push_back(mk(CMD_UPDATE, 512, 1, 0));
    table_rows.push_back(mk(CMD_QUERY, 2, 0, 1));
    table_rows.push_back(mk(CMD_QUERY, 512, 0, 0, 1, 0, 0));
    table_rows.push_back(mk(CMD_UPDATE, 511, 7, 0));
    table_rows.push_back(mk(CMD_QUERY, 511, 0, 6));
    table_rows.push_back(mk(CMD_QUERY, 1, 32'hFFFF_FFFF, 7));
    table_rows.push_back(mk(CMD_UPDATE, 1023, 0, 0));
    table_rows.push_back(mk(CMD_UPDATE, 0, 0, 0));
    table_rows.push_back(mk(CMD_QUERY, 600, 0, 32'hFFFF_FFFF, 1, 0, 0));
    foreach (table_rows[i]) begin
      send(table_rows[i]);
      idle_gap();
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      row = mk(($urandom_range(0, 1) == 1) ? CMD_QUERY : CMD_UPDATE,
               ($urandom_range(0, 3) == 0) ? idx_t'($urandom()) : idx_t'($urandom_range(0, 63)),
               pick_value(), pick_threshold());
      if ($urandom_range(0, 7) == 0) row.value = $urandom();
      send(row);
      if (n == 100) hold_request <= 1'b1;
      if (n < 90 || n > 110) idle_gap();
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    waited = 0;
    while (pending_runs.size() != 0 && waited < 200_000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && pending_runs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
